// ===== hw/rtl/csc_pkg.sv =====
// csc_pkg: shared types and fixed constants for the circle/segment hit test.
// No dependencies; every csc_* module and the top level refer to it by scope.
package csc_pkg;

   localparam int RADIUS_BITS = 15;
   localparam int R2_BITS     = 2 * RADIUS_BITS;

   // decision bits carried from the squaring stages to the output stage
   typedef struct packed {
      logic between;   // centre projects onto the segment
      logic blen_nz;   // segment has nonzero length
      logic near;      // an end point lies within the radius
   } csc_flags_type;

endpackage

// ===== hw/rtl/csc_delta.sv =====
// csc_delta: first pipeline stage, coordinate differences A, B, C.
// Depends on csc_pkg.
module csc_delta #(
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [COORD_BITS-1:0]        center_x,
   input  logic signed [COORD_BITS-1:0]        center_y,
   input  logic        [csc_pkg::RADIUS_BITS-1:0] radius,
   input  logic signed [COORD_BITS-1:0]        start_x,
   input  logic signed [COORD_BITS-1:0]        start_y,
   input  logic signed [COORD_BITS-1:0]        end_x,
   input  logic signed [COORD_BITS-1:0]        end_y,
   output logic                                out_valid,
   output logic signed [COORD_BITS:0]          ax,
   output logic signed [COORD_BITS:0]          ay,
   output logic signed [COORD_BITS:0]          bx,
   output logic signed [COORD_BITS:0]          by,
   output logic signed [COORD_BITS:0]          qx,
   output logic signed [COORD_BITS:0]          qy,
   output logic        [csc_pkg::RADIUS_BITS-1:0] radius_out
);

   localparam int DW = COORD_BITS + 1;

   logic                               valid_ff;
   logic signed [DW-1:0]               ax_in, ay_in, bx_in, by_in, qx_in, qy_in;
   logic signed [DW-1:0]               ax_ff, ay_ff, bx_ff, by_ff, qx_ff, qy_ff;
   logic [csc_pkg::RADIUS_BITS-1:0]    radius_ff;

   assign ax_in = DW'(center_x) - DW'(start_x);
   assign ay_in = DW'(center_y) - DW'(start_y);
   assign bx_in = DW'(end_x)    - DW'(start_x);
   assign by_in = DW'(end_y)    - DW'(start_y);
   assign qx_in = DW'(center_x) - DW'(end_x);
   assign qy_in = DW'(center_y) - DW'(end_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         bx_ff     <= bx_in;
         by_ff     <= by_in;
         qx_ff     <= qx_in;
         qy_ff     <= qy_in;
         radius_ff <= radius;
      end
   end

   assign out_valid  = valid_ff;
   assign ax         = ax_ff;
   assign ay         = ay_ff;
   assign bx         = bx_ff;
   assign by         = by_ff;
   assign qx         = qx_ff;
   assign qy         = qy_ff;
   assign radius_out = radius_ff;

endmodule

// ===== hw/rtl/csc_mult.sv =====
// csc_mult: second pipeline stage, the twelve coordinate products and radius^2.
// Depends on csc_pkg.
module csc_mult #(
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [COORD_BITS:0]             ax,
   input  logic signed [COORD_BITS:0]             ay,
   input  logic signed [COORD_BITS:0]             bx,
   input  logic signed [COORD_BITS:0]             by,
   input  logic signed [COORD_BITS:0]             qx,
   input  logic signed [COORD_BITS:0]             qy,
   input  logic        [csc_pkg::RADIUS_BITS-1:0] radius,
   output logic                                   out_valid,
   output logic signed [2*COORD_BITS+1:0]         axbx,
   output logic signed [2*COORD_BITS+1:0]         ayby,
   output logic signed [2*COORD_BITS+1:0]         bxqx,
   output logic signed [2*COORD_BITS+1:0]         byqy,
   output logic signed [2*COORD_BITS+1:0]         axby,
   output logic signed [2*COORD_BITS+1:0]         bxay,
   output logic signed [2*COORD_BITS+1:0]         axax,
   output logic signed [2*COORD_BITS+1:0]         ayay,
   output logic signed [2*COORD_BITS+1:0]         qxqx,
   output logic signed [2*COORD_BITS+1:0]         qyqy,
   output logic signed [2*COORD_BITS+1:0]         bxbx,
   output logic signed [2*COORD_BITS+1:0]         byby,
   output logic        [csc_pkg::R2_BITS-1:0]     r2
);

   localparam int PW = 2 * COORD_BITS + 2;
   localparam int RW = csc_pkg::R2_BITS;

   logic                 valid_ff;
   logic signed [PW-1:0] axbx_in, ayby_in, bxqx_in, byqy_in, axby_in, bxay_in;
   logic signed [PW-1:0] axax_in, ayay_in, qxqx_in, qyqy_in, bxbx_in, byby_in;
   logic signed [PW-1:0] axbx_ff, ayby_ff, bxqx_ff, byqy_ff, axby_ff, bxay_ff;
   logic signed [PW-1:0] axax_ff, ayay_ff, qxqx_ff, qyqy_ff, bxbx_ff, byby_ff;
   logic [RW-1:0]        r2_in, r2_ff;

   // operands sign-extend to the product width; true products always fit
   assign axbx_in = PW'(ax) * PW'(bx);
   assign ayby_in = PW'(ay) * PW'(by);
   assign bxqx_in = PW'(bx) * PW'(qx);
   assign byqy_in = PW'(by) * PW'(qy);
   assign axby_in = PW'(ax) * PW'(by);
   assign bxay_in = PW'(bx) * PW'(ay);
   assign axax_in = PW'(ax) * PW'(ax);
   assign ayay_in = PW'(ay) * PW'(ay);
   assign qxqx_in = PW'(qx) * PW'(qx);
   assign qyqy_in = PW'(qy) * PW'(qy);
   assign bxbx_in = PW'(bx) * PW'(bx);
   assign byby_in = PW'(by) * PW'(by);
   assign r2_in   = RW'(radius) * RW'(radius);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axbx_ff <= axbx_in;
         ayby_ff <= ayby_in;
         bxqx_ff <= bxqx_in;
         byqy_ff <= byqy_in;
         axby_ff <= axby_in;
         bxay_ff <= bxay_in;
         axax_ff <= axax_in;
         ayay_ff <= ayay_in;
         qxqx_ff <= qxqx_in;
         qyqy_ff <= qyqy_in;
         bxbx_ff <= bxbx_in;
         byby_ff <= byby_in;
         r2_ff   <= r2_in;
      end
   end

   assign out_valid = valid_ff;
   assign axbx      = axbx_ff;
   assign ayby      = ayby_ff;
   assign bxqx      = bxqx_ff;
   assign byqy      = byqy_ff;
   assign axby      = axby_ff;
   assign bxay      = bxay_ff;
   assign axax      = axax_ff;
   assign ayay      = ayay_ff;
   assign qxqx      = qxqx_ff;
   assign qyqy      = qyqy_ff;
   assign bxbx      = bxbx_ff;
   assign byby      = byby_ff;
   assign r2        = r2_ff;

endmodule

// ===== hw/rtl/csc_reduce.sv =====
// csc_reduce: third pipeline stage, dot products, |cross| and squared lengths.
// Depends on csc_pkg.
module csc_reduce #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [2*COORD_BITS+1:0]     axbx,
   input  logic signed [2*COORD_BITS+1:0]     ayby,
   input  logic signed [2*COORD_BITS+1:0]     bxqx,
   input  logic signed [2*COORD_BITS+1:0]     byqy,
   input  logic signed [2*COORD_BITS+1:0]     axby,
   input  logic signed [2*COORD_BITS+1:0]     bxay,
   input  logic signed [2*COORD_BITS+1:0]     axax,
   input  logic signed [2*COORD_BITS+1:0]     ayay,
   input  logic signed [2*COORD_BITS+1:0]     qxqx,
   input  logic signed [2*COORD_BITS+1:0]     qyqy,
   input  logic signed [2*COORD_BITS+1:0]     bxbx,
   input  logic signed [2*COORD_BITS+1:0]     byby,
   input  logic        [csc_pkg::R2_BITS-1:0] r2,
   output logic                               out_valid,
   output logic signed [2*COORD_BITS+1:0]     dab,
   output logic signed [2*COORD_BITS+1:0]     dbc,
   output logic        [2*COORD_BITS:0]       cr,
   output logic        [2*COORD_BITS:0]       blen2,
   output logic        [2*COORD_BITS:0]       alen2,
   output logic        [2*COORD_BITS:0]       clen2,
   output logic        [csc_pkg::R2_BITS-1:0] r2_out
);

   localparam int PW = 2 * COORD_BITS + 2;
   localparam int MW = 2 * COORD_BITS + 1;

   logic                          valid_ff;
   logic signed [PW-1:0]          dab_in, dbc_in, dab_ff, dbc_ff;
   logic signed [PW-1:0]          cross_pos, cross_neg;
   logic signed [PW-1:0]          blen_sum, alen_sum, clen_sum;
   logic [MW-1:0]                 cr_in, blen2_in, alen2_in, clen2_in;
   logic [MW-1:0]                 cr_ff, blen2_ff, alen2_ff, clen2_ff;
   logic [csc_pkg::R2_BITS-1:0]   r2_ff;

   assign dab_in = axbx + ayby;
   assign dbc_in = bxqx + byqy;

   // |cross|: both differences in parallel, the compare picks the positive one
   assign cross_pos = axby - bxay;
   assign cross_neg = bxay - axby;
   assign cr_in     = (axby >= bxay) ? cross_pos[MW-1:0] : cross_neg[MW-1:0];

   // sums of squares are never negative and fit MW bits
   assign blen_sum = bxbx + byby;
   assign alen_sum = axax + ayay;
   assign clen_sum = qxqx + qyqy;
   assign blen2_in = blen_sum[MW-1:0];
   assign alen2_in = alen_sum[MW-1:0];
   assign clen2_in = clen_sum[MW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dab_ff   <= dab_in;
         dbc_ff   <= dbc_in;
         cr_ff    <= cr_in;
         blen2_ff <= blen2_in;
         alen2_ff <= alen2_in;
         clen2_ff <= clen2_in;
         r2_ff    <= r2;
      end
   end

   assign out_valid = valid_ff;
   assign dab       = dab_ff;
   assign dbc       = dbc_ff;
   assign cr        = cr_ff;
   assign blen2     = blen2_ff;
   assign alen2     = alen2_ff;
   assign clen2     = clen2_ff;
   assign r2_out    = r2_ff;

endmodule

// ===== hw/rtl/csc_square.sv =====
// csc_square: stages four and five, decision flags and split squaring of |cross|
// and r^2*|B|^2 as partial products, then their recombination. Depends on csc_pkg.
module csc_square #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [1:0]                         en,          // [0] stage 4, [1] stage 5
   input  logic                               in_valid,
   input  logic signed [2*COORD_BITS+1:0]     dab,
   input  logic signed [2*COORD_BITS+1:0]     dbc,
   input  logic        [2*COORD_BITS:0]       cr,
   input  logic        [2*COORD_BITS:0]       blen2,
   input  logic        [2*COORD_BITS:0]       alen2,
   input  logic        [2*COORD_BITS:0]       clen2,
   input  logic        [csc_pkg::R2_BITS-1:0] r2,
   output logic [1:0]                         stage_valid,
   output csc_pkg::csc_flags_type             flags,
   output logic [2*(2*COORD_BITS+1)+csc_pkg::R2_BITS-1:0] lhs,
   output logic [2*(2*COORD_BITS+1)+csc_pkg::R2_BITS-1:0] rhs
);

   localparam int PW = 2 * COORD_BITS + 2;
   localparam int MW = 2 * COORD_BITS + 1;
   localparam int LB = COORD_BITS + 1;        // low half width
   localparam int HB = MW - LB;               // high half width
   localparam int RW = csc_pkg::R2_BITS;
   localparam int NW = (MW > RW) ? MW : RW;
   localparam int LW = 2 * MW + RW;

   logic [HB-1:0]           cr_hi, bl_hi;
   logic [LB-1:0]           cr_lo, bl_lo;

   logic                    valid4_ff, valid5_ff;
   csc_pkg::csc_flags_type  flags4_in, flags4_ff, flags5_ff;
   logic [2*HB-1:0]         hh_in, hh_ff;
   logic [HB+LB-1:0]        hl_in, hl_ff;
   logic [2*LB-1:0]         ll_in, ll_ff;
   logic [RW+HB-1:0]        rbh_in, rbh_ff;
   logic [RW+LB-1:0]        rbl_in, rbl_ff;
   logic [LW-1:0]           lhs_in, rhs_in, lhs_ff, rhs_ff;

   assign cr_lo = cr[LB-1:0];
   assign cr_hi = cr[MW-1:LB];
   assign bl_lo = blen2[LB-1:0];
   assign bl_hi = blen2[MW-1:LB];

   // stage 4: decision flags and partial products
   assign flags4_in.between = (dab == PW'(0)) || (dbc == PW'(0)) ||
                              (dab[PW-1] != dbc[PW-1]);
   assign flags4_in.blen_nz = (blen2 != MW'(0));
   assign flags4_in.near    = (NW'(alen2) <= NW'(r2)) || (NW'(clen2) <= NW'(r2));

   assign hh_in  = (2*HB)'(cr_hi) * (2*HB)'(cr_hi);
   assign hl_in  = (HB+LB)'(cr_hi) * (HB+LB)'(cr_lo);
   assign ll_in  = (2*LB)'(cr_lo) * (2*LB)'(cr_lo);
   assign rbh_in = (RW+HB)'(r2) * (RW+HB)'(bl_hi);
   assign rbl_in = (RW+LB)'(r2) * (RW+LB)'(bl_lo);

   // stage 5: cr^2 = hh<<2L + 2*hl<<L + ll ; r2*blen2 = rbh<<L + rbl
   assign lhs_in = (LW'(hh_ff) << (2*LB)) + (LW'(hl_ff) << (LB+1)) + LW'(ll_ff);
   assign rhs_in = (LW'(rbh_ff) << LB) + LW'(rbl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         if (en[0]) begin
            valid4_ff <= in_valid;
         end
         if (en[1]) begin
            valid5_ff <= valid4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         flags4_ff <= flags4_in;
         hh_ff     <= hh_in;
         hl_ff     <= hl_in;
         ll_ff     <= ll_in;
         rbh_ff    <= rbh_in;
         rbl_ff    <= rbl_in;
      end
      if (en[1]) begin
         flags5_ff <= flags4_ff;
         lhs_ff    <= lhs_in;
         rhs_ff    <= rhs_in;
      end
   end

   assign stage_valid = {valid5_ff, valid4_ff};
   assign flags       = flags5_ff;
   assign lhs         = lhs_ff;
   assign rhs         = rhs_ff;

endmodule

// ===== hw/rtl/circle_segment_collision.sv =====
// circle_segment_collision: top level of the circle versus segment hit test.
// Depends on csc_pkg, csc_delta, csc_mult, csc_reduce and csc_square.
//
//   channel  dir  handshake              payload
//   req_     in   req_valid / req_stall  center_x/y, radius, start_x/y, end_x/y
//   rsp_     out  rsp_valid / rsp_stall  hit
//
// One beat per cycle sustained while rsp_stall is low; six register stages.
// Stages: differences, products, sums and |cross|, partial products of the
//   two squares, recombination, final compare into the output register.
// Each stage holds only while it is full and the stage after it is blocked,
//   so bubbles close up; req_stall rises only when every stage is full and the
//   output beat is stalled.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
//
// Hit rule: A = c - s, B = e - s, C = c - e. When dot(A,B) and dot(B,C) differ
// in sign or either is zero, hit iff |B| != 0 and cross(A,B)^2 <= r^2*|B|^2,
// compared exactly. Otherwise hit iff either end point is within r of c.
module circle_segment_collision #(
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_BITS-1:0]        req_center_x,
   input  logic signed [COORD_BITS-1:0]        req_center_y,
   input  logic        [csc_pkg::RADIUS_BITS-1:0] req_radius,
   input  logic signed [COORD_BITS-1:0]        req_start_x,
   input  logic signed [COORD_BITS-1:0]        req_start_y,
   input  logic signed [COORD_BITS-1:0]        req_end_x,
   input  logic signed [COORD_BITS-1:0]        req_end_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;
   localparam int MW = 2 * COORD_BITS + 1;
   localparam int RB = csc_pkg::RADIUS_BITS;
   localparam int RW = csc_pkg::R2_BITS;
   localparam int LW = 2 * MW + RW;

   // per-stage advance: stage k loads when it is empty or stage k+1 loads
   logic [5:0] adv;

   // stage 1 outputs
   logic                 v1;
   logic signed [DW-1:0] ax, ay, bx, by, qx, qy;
   logic [RB-1:0]        radius1;

   // stage 2 outputs
   logic                 v2;
   logic signed [PW-1:0] axbx, ayby, bxqx, byqy, axby, bxay;
   logic signed [PW-1:0] axax, ayay, qxqx, qyqy, bxbx, byby;
   logic [RW-1:0]        r2_2;

   // stage 3 outputs
   logic                 v3;
   logic signed [PW-1:0] dab, dbc;
   logic [MW-1:0]        cr, blen2, alen2, clen2;
   logic [RW-1:0]        r2_3;

   // stages 4 and 5
   logic [1:0]             v45;
   csc_pkg::csc_flags_type flags5;
   logic [LW-1:0]          lhs5, rhs5;

   // stage 6: output register
   logic rsp_valid_ff;
   logic rsp_hit_in, rsp_hit_ff;

   always_comb begin
      adv[5] = !rsp_valid_ff || !rsp_stall;
      adv[4] = !v45[1] || adv[5];
      adv[3] = !v45[0] || adv[4];
      adv[2] = !v3     || adv[3];
      adv[1] = !v2     || adv[2];
      adv[0] = !v1     || adv[1];
   end

   assign req_stall = !adv[0];

   csc_delta #(.COORD_BITS(COORD_BITS)) u_delta (
      .clock      (clock),
      .reset      (reset),
      .en         (adv[0]),
      .in_valid   (req_valid),
      .center_x   (req_center_x),
      .center_y   (req_center_y),
      .radius     (req_radius),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .out_valid  (v1),
      .ax         (ax),
      .ay         (ay),
      .bx         (bx),
      .by         (by),
      .qx         (qx),
      .qy         (qy),
      .radius_out (radius1)
   );

   csc_mult #(.COORD_BITS(COORD_BITS)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .en        (adv[1]),
      .in_valid  (v1),
      .ax        (ax),
      .ay        (ay),
      .bx        (bx),
      .by        (by),
      .qx        (qx),
      .qy        (qy),
      .radius    (radius1),
      .out_valid (v2),
      .axbx      (axbx),
      .ayby      (ayby),
      .bxqx      (bxqx),
      .byqy      (byqy),
      .axby      (axby),
      .bxay      (bxay),
      .axax      (axax),
      .ayay      (ayay),
      .qxqx      (qxqx),
      .qyqy      (qyqy),
      .bxbx      (bxbx),
      .byby      (byby),
      .r2        (r2_2)
   );

   csc_reduce #(.COORD_BITS(COORD_BITS)) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .en        (adv[2]),
      .in_valid  (v2),
      .axbx      (axbx),
      .ayby      (ayby),
      .bxqx      (bxqx),
      .byqy      (byqy),
      .axby      (axby),
      .bxay      (bxay),
      .axax      (axax),
      .ayay      (ayay),
      .qxqx      (qxqx),
      .qyqy      (qyqy),
      .bxbx      (bxbx),
      .byby      (byby),
      .r2        (r2_2),
      .out_valid (v3),
      .dab       (dab),
      .dbc       (dbc),
      .cr        (cr),
      .blen2     (blen2),
      .alen2     (alen2),
      .clen2     (clen2),
      .r2_out    (r2_3)
   );

   csc_square #(.COORD_BITS(COORD_BITS)) u_square (
      .clock       (clock),
      .reset       (reset),
      .en          (adv[4:3]),
      .in_valid    (v3),
      .dab         (dab),
      .dbc         (dbc),
      .cr          (cr),
      .blen2       (blen2),
      .alen2       (alen2),
      .clen2       (clen2),
      .r2          (r2_3),
      .stage_valid (v45),
      .flags       (flags5),
      .lhs         (lhs5),
      .rhs         (rhs5)
   );

   // a zero-length segment on the projection branch never hits
   assign rsp_hit_in = flags5.between ? (flags5.blen_nz && (lhs5 <= rhs5)) : flags5.near;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv[5]) begin
         rsp_valid_ff <= v45[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         rsp_hit_ff <= rsp_hit_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

// ===== hw/rtl/csc_checker.sv =====
// csc_checker: port-level assertions for circle_segment_collision, bound to it.
// Depends on csc_pkg and the circle_segment_collision port list.
module csc_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic signed [COORD_BITS-1:0]        req_center_x,
   input logic signed [COORD_BITS-1:0]        req_center_y,
   input logic        [csc_pkg::RADIUS_BITS-1:0] req_radius,
   input logic signed [COORD_BITS-1:0]        req_start_x,
   input logic signed [COORD_BITS-1:0]        req_start_y,
   input logic signed [COORD_BITS-1:0]        req_end_x,
   input logic signed [COORD_BITS-1:0]        req_end_y,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_hit
);

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled request beat holds until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_center_x)
         && $stable(req_center_y) && $stable(req_radius) && $stable(req_start_x)
         && $stable(req_start_y) && $stable(req_end_x) && $stable(req_end_y))
      else $error("stalled request beat changed");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit))
      else $error("stalled result beat changed");

   // input back-pressure only when the output beat is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without output back-pressure");

   // with no output stall, an accepted beat reaches rsp_valid after passing every stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted beat did not reach the output");

endmodule

bind circle_segment_collision csc_checker #(.COORD_BITS(COORD_BITS)) u_csc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_center_x (req_center_x),
   .req_center_y (req_center_y),
   .req_radius   (req_radius),
   .req_start_x  (req_start_x),
   .req_start_y  (req_start_y),
   .req_end_x    (req_end_x),
   .req_end_y    (req_end_y),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_hit      (rsp_hit)
);
